// ===== sv/bis_pkg.sv =====
// ----------------------------------------------------------------------------
// bis_pkg: shared definitions of the bilinear image scaler
// Field widths, register indexes, reset values and the size and step bundles
// that pass between the control registers, the step divider and the front end.
// ----------------------------------------------------------------------------
package bis_pkg;

   // Widths of the item fields.
   localparam int COL_W = 6;
   localparam int ROW_W = 6;
   localparam int CH_W  = 8;
   localparam int PIX_W = 3 * CH_W;

   // Size registers and 8.16 steps.
   localparam int SIZE_W    = 7;
   localparam int FRAC_BITS = 16;
   localparam int STEP_W    = 24;

   // Sample position: target column times step.
   localparam int POS_W     = COL_W + STEP_W;
   localparam int POS_INT_W = POS_W - FRAC_BITS;

   // Step divider: dividend is the source size shifted up by the fraction.
   localparam int DIV_W     = SIZE_W + FRAC_BITS;
   localparam int DIV_CNT_W = $clog2(DIV_W + 1);

   // Stream and register port widths.
   localparam int REQ_DATA_W  = 40;
   localparam int RSP_DATA_W  = PIX_W;
   localparam int CSR_INDEX_W = 4;

   // Result slots that the back end may reserve ahead of delivery.
   localparam int RESULT_SLOTS = 2;
   localparam int SLOT_CNT_W   = 2;

   // Operation codes carried in tuser.
   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   // Smallest size that the blend accepts, and register reset values.
   localparam logic [SIZE_W-1:0] MIN_SIZE             = 7'd2;
   localparam logic [SIZE_W-1:0] RESET_SOURCE_WIDTH  = 7'd64;
   localparam logic [SIZE_W-1:0] RESET_SOURCE_HEIGHT = 7'd64;
   localparam logic [SIZE_W-1:0] RESET_TARGET_WIDTH  = 7'd32;
   localparam logic [SIZE_W-1:0] RESET_TARGET_HEIGHT = 7'd32;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_SOURCE_WIDTH  = 4'd0,
      REG_SOURCE_HEIGHT = 4'd1,
      REG_TARGET_WIDTH  = 4'd2,
      REG_TARGET_HEIGHT = 4'd3
   } csr_index_type;

   // Effective frame sizes after saturation.
   typedef struct packed {
      logic [SIZE_W-1:0] src_w;
      logic [SIZE_W-1:0] src_h;
      logic [SIZE_W-1:0] tgt_w;
      logic [SIZE_W-1:0] tgt_h;
   } sizes_type;

   // Horizontal and vertical steps in 8.16 fixed point.
   typedef struct packed {
      logic [STEP_W-1:0] step_x;
      logic [STEP_W-1:0] step_y;
   } steps_type;

endpackage

// ===== sv/bis_step_div.sv =====
// ----------------------------------------------------------------------------
// bis_step_div: step divider
// Works out step_x and step_y as (source size << 16) / target size with one
// shared restoring divider, one quotient bit a cycle, horizontal step first.
// ----------------------------------------------------------------------------
module bis_step_div (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  bis_pkg::sizes_type  sizes,
   output bis_pkg::steps_type  steps,
   output logic                busy
);

   typedef enum logic [1:0] {
      DV_IDLE,
      DV_X,
      DV_Y
   } state_type;

   state_type                        state_ff;
   logic [bis_pkg::DIV_CNT_W-1:0]    cnt_ff;
   logic [bis_pkg::SIZE_W-1:0]       rem_ff;
   logic [bis_pkg::DIV_W-1:0]        quo_ff;
   bis_pkg::steps_type               steps_ff;

   logic [bis_pkg::SIZE_W-1:0]       divisor;
   logic [bis_pkg::SIZE_W:0]         trial;
   logic [bis_pkg::SIZE_W:0]         diff;
   logic                             fits;
   logic [bis_pkg::SIZE_W-1:0]       rem_in;
   logic [bis_pkg::DIV_W-1:0]        quo_in;
   logic                             last_step;

   // One restoring step: shift in the next dividend bit and try a subtract.
   always_comb begin
      divisor   = (state_ff == DV_Y) ? sizes.tgt_h : sizes.tgt_w;
      trial     = {rem_ff, quo_ff[bis_pkg::DIV_W-1]};
      diff      = trial - {1'b0, divisor};
      fits      = (trial >= {1'b0, divisor});
      rem_in    = fits ? diff[bis_pkg::SIZE_W-1:0] : trial[bis_pkg::SIZE_W-1:0];
      quo_in    = {quo_ff[bis_pkg::DIV_W-2:0], fits};
      last_step = (cnt_ff == bis_pkg::DIV_CNT_W'(1));
   end

   // Sequencer, partial remainder and the finished steps.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DV_IDLE;
         cnt_ff   <= '0;
      end else begin
         unique case (state_ff)
            DV_IDLE: begin
               if (start) begin
                  state_ff <= DV_X;
                  rem_ff   <= '0;
                  quo_ff   <= {sizes.src_w, {bis_pkg::FRAC_BITS{1'b0}}};
                  cnt_ff   <= bis_pkg::DIV_CNT_W'(bis_pkg::DIV_W);
               end
            end
            DV_X: begin
               if (last_step) begin
                  steps_ff.step_x <= bis_pkg::STEP_W'(quo_in);
                  state_ff        <= DV_Y;
                  rem_ff          <= '0;
                  quo_ff          <= {sizes.src_h, {bis_pkg::FRAC_BITS{1'b0}}};
                  cnt_ff          <= bis_pkg::DIV_CNT_W'(bis_pkg::DIV_W);
               end else begin
                  rem_ff <= rem_in;
                  quo_ff <= quo_in;
                  cnt_ff <= cnt_ff - 1'b1;
               end
            end
            DV_Y: begin
               if (last_step) begin
                  steps_ff.step_y <= bis_pkg::STEP_W'(quo_in);
                  state_ff        <= DV_IDLE;
               end else begin
                  rem_ff <= rem_in;
                  quo_ff <= quo_in;
                  cnt_ff <= cnt_ff - 1'b1;
               end
            end
            default: begin
               state_ff <= DV_IDLE;
            end
         endcase
      end
   end

   assign steps = steps_ff;
   assign busy  = (state_ff != DV_IDLE);

endmodule

// ===== sv/bis_front.sv =====
// ----------------------------------------------------------------------------
// bis_front: item classifier and address generator
// Accepts load and sample items, clamps the target position, forms the sample
// position, the four neighbour addresses and the two weights, and hands out jobs.
// ----------------------------------------------------------------------------
module bis_front #(
   parameter int MAX_WIDTH   = 64,
   parameter int MAX_HEIGHT  = 64,
   parameter int WEIGHT_BITS = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic                          in_op,
   input  logic [bis_pkg::COL_W-1:0]     in_column,
   input  logic [bis_pkg::ROW_W-1:0]     in_row,
   input  logic [bis_pkg::PIX_W-1:0]     in_pixel,
   input  bis_pkg::sizes_type            sizes,
   input  bis_pkg::steps_type            steps,
   output logic                          job_valid,
   input  logic                          job_ready,
   output logic [1 + bis_pkg::PIX_W + 2*WEIGHT_BITS
                 + 4*$clog2(MAX_WIDTH*MAX_HEIGHT) - 1:0] job_data
);

   localparam int ADDR_W = $clog2(MAX_WIDTH * MAX_HEIGHT);

   typedef struct packed {
      logic                          is_load;
      logic [bis_pkg::PIX_W-1:0]     pixel;
      logic [WEIGHT_BITS-1:0]        wa;
      logic [WEIGHT_BITS-1:0]        wb;
      logic [3:0][ADDR_W-1:0]        addr;
   } job_type;

   // Store address of a pixel, row-major.
   function automatic logic [ADDR_W-1:0] addr_of(input logic [bis_pkg::POS_INT_W-1:0] x,
                                                 input logic [bis_pkg::POS_INT_W-1:0] y);
      return ADDR_W'(y) * ADDR_W'(MAX_WIDTH) + ADDR_W'(x);
   endfunction

   // First stage: classified item.
   logic                             s1_valid_ff;
   logic                             s1_load_ff;
   logic [ADDR_W-1:0]                s1_addr_ff;
   logic [bis_pkg::PIX_W-1:0]        s1_pixel_ff;
   logic [bis_pkg::COL_W-1:0]        s1_col_ff;
   logic [bis_pkg::ROW_W-1:0]        s1_row_ff;
   logic                             s1_last_col_ff;
   logic                             s1_last_row_ff;

   // Second stage: sample position.
   logic                             s2_valid_ff;
   logic                             s2_load_ff;
   logic [ADDR_W-1:0]                s2_addr_ff;
   logic [bis_pkg::PIX_W-1:0]        s2_pixel_ff;
   logic [bis_pkg::POS_W-1:0]        s2_px_ff;
   logic [bis_pkg::POS_W-1:0]        s2_py_ff;
   logic                             s2_last_col_ff;
   logic                             s2_last_row_ff;

   logic                             s2_ready;
   logic                             load_in_range;
   logic                             s1_valid_in;
   logic [bis_pkg::SIZE_W-1:0]       tgt_w_m1;
   logic [bis_pkg::SIZE_W-1:0]       tgt_h_m1;
   logic [bis_pkg::COL_W-1:0]        col_in;
   logic [bis_pkg::ROW_W-1:0]        row_in;
   logic [bis_pkg::POS_INT_W-1:0]    src_w_m1;
   logic [bis_pkg::POS_INT_W-1:0]    src_h_m1;
   logic [bis_pkg::POS_INT_W-1:0]    px_int;
   logic [bis_pkg::POS_INT_W-1:0]    py_int;
   logic [bis_pkg::POS_INT_W-1:0]    ix;
   logic [bis_pkg::POS_INT_W-1:0]    iy;
   logic [bis_pkg::POS_INT_W-1:0]    ix1;
   logic [bis_pkg::POS_INT_W-1:0]    iy1;
   logic                             corner;
   job_type                          job;

   // Stall chain: each stage moves when the one after it has room.
   assign s2_ready  = !s2_valid_ff || job_ready;
   assign in_ready  = !s1_valid_ff || s2_ready;
   assign job_valid = s2_valid_ff;

   // Classification: loads outside the store are dropped, sample positions
   // saturate to the last target column and row.
   always_comb begin
      load_in_range = (int'(in_column) < MAX_WIDTH) && (int'(in_row) < MAX_HEIGHT);
      s1_valid_in   = in_valid && ((in_op == bis_pkg::OP_SAMPLE) || load_in_range);
      tgt_w_m1      = sizes.tgt_w - 1'b1;
      tgt_h_m1      = sizes.tgt_h - 1'b1;
      col_in        = ({1'b0, in_column} > tgt_w_m1) ? tgt_w_m1[bis_pkg::COL_W-1:0]
                                                     : in_column;
      row_in        = ({1'b0, in_row} > tgt_h_m1) ? tgt_h_m1[bis_pkg::ROW_W-1:0]
                                                  : in_row;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (in_ready) begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         s1_load_ff     <= (in_op == bis_pkg::OP_LOAD);
         s1_addr_ff     <= addr_of(bis_pkg::POS_INT_W'(in_column),
                                   bis_pkg::POS_INT_W'(in_row));
         s1_pixel_ff    <= in_pixel;
         s1_col_ff      <= col_in;
         s1_row_ff      <= row_in;
         s1_last_col_ff <= ({1'b0, col_in} == tgt_w_m1);
         s1_last_row_ff <= ({1'b0, row_in} == tgt_h_m1);
      end
   end

   // Sample position in 14.16: target index times step.
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff && s2_ready) begin
         s2_load_ff     <= s1_load_ff;
         s2_addr_ff     <= s1_addr_ff;
         s2_pixel_ff    <= s1_pixel_ff;
         s2_px_ff       <= bis_pkg::POS_W'(s1_col_ff) * bis_pkg::POS_W'(steps.step_x);
         s2_py_ff       <= bis_pkg::POS_W'(s1_row_ff) * bis_pkg::POS_W'(steps.step_y);
         s2_last_col_ff <= s1_last_col_ff;
         s2_last_row_ff <= s1_last_row_ff;
      end
   end

   // Neighbour indices clamp to the source edge; the bottom-right target
   // pixel takes the source corner with full weight on it.
   always_comb begin
      src_w_m1 = bis_pkg::POS_INT_W'(sizes.src_w - 1'b1);
      src_h_m1 = bis_pkg::POS_INT_W'(sizes.src_h - 1'b1);
      px_int   = s2_px_ff[bis_pkg::POS_W-1:bis_pkg::FRAC_BITS];
      py_int   = s2_py_ff[bis_pkg::POS_W-1:bis_pkg::FRAC_BITS];
      corner   = s2_last_col_ff && s2_last_row_ff;

      ix  = (corner || (px_int > src_w_m1)) ? src_w_m1 : px_int;
      iy  = (corner || (py_int > src_h_m1)) ? src_h_m1 : py_int;
      ix1 = (ix == src_w_m1) ? ix : ix + 1'b1;
      iy1 = (iy == src_h_m1) ? iy : iy + 1'b1;

      job.is_load = s2_load_ff;
      job.pixel   = s2_pixel_ff;
      job.wa      = s2_last_col_ff ? '0
                    : s2_px_ff[bis_pkg::FRAC_BITS-1 -: WEIGHT_BITS];
      job.wb      = s2_last_row_ff ? '0
                    : s2_py_ff[bis_pkg::FRAC_BITS-1 -: WEIGHT_BITS];
      job.addr[0] = s2_load_ff ? s2_addr_ff : addr_of(ix, iy);
      job.addr[1] = addr_of(ix1, iy);
      job.addr[2] = addr_of(ix, iy1);
      job.addr[3] = addr_of(ix1, iy1);
   end

   assign job_data = job;

endmodule

// ===== sv/bis_queue.sv =====
// ----------------------------------------------------------------------------
// bis_queue: two-entry queue
// Decouples a producer from a consumer so that each side can stall on its
// own without losing a transaction.
// ----------------------------------------------------------------------------
module bis_queue #(
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  logic [DATA_W-1:0] push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output logic [DATA_W-1:0] pop_data
);

   logic [DATA_W-1:0] slots_ff [2];
   logic              wr_ptr_ff;
   logic              rd_ptr_ff;
   logic [1:0]        count_ff;
   logic              push;
   logic              pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = slots_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // Pointers and fill level.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== sv/bis_back.sv =====
// ----------------------------------------------------------------------------
// bis_back: pixel store and blend engine
// Writes loaded pixels into the single-port store and, for a sample job,
// reads the four neighbours one a cycle and accumulates the weighted sum.
// ----------------------------------------------------------------------------
module bis_back #(
   parameter int MAX_WIDTH   = 64,
   parameter int MAX_HEIGHT  = 64,
   parameter int WEIGHT_BITS = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          job_valid,
   output logic                          job_ready,
   input  logic [1 + bis_pkg::PIX_W + 2*WEIGHT_BITS
                 + 4*$clog2(MAX_WIDTH*MAX_HEIGHT) - 1:0] job_data,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [bis_pkg::PIX_W-1:0]     out_pixel
);

   localparam int ADDR_W = $clog2(MAX_WIDTH * MAX_HEIGHT);
   localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
   localparam int WX_W   = WEIGHT_BITS + 1;
   localparam int W_W    = 2 * WEIGHT_BITS + 1;
   localparam int ACC_W  = 2 * WEIGHT_BITS + bis_pkg::CH_W;
   localparam logic [WX_W-1:0] ONE = {1'b1, {WEIGHT_BITS{1'b0}}};

   typedef struct packed {
      logic                          is_load;
      logic [bis_pkg::PIX_W-1:0]     pixel;
      logic [WEIGHT_BITS-1:0]        wa;
      logic [WEIGHT_BITS-1:0]        wb;
      logic [3:0][ADDR_W-1:0]        addr;
   } job_type;

   typedef enum logic {
      BK_IDLE,
      BK_GATHER
   } state_type;

   logic [bis_pkg::PIX_W-1:0]        mem [DEPTH];

   state_type                        state_ff;
   logic [1:0]                       tap_ff;
   job_type                          cur_ff;
   logic [bis_pkg::SLOT_CNT_W-1:0]   pending_ff;
   logic [bis_pkg::SLOT_CNT_W-1:0]   pending_in;

   job_type                          head;
   job_type                          sel;
   logic [1:0]                       tap;
   logic                             start_load;
   logic                             start_sample;
   logic                             read_en;
   logic [ADDR_W-1:0]                mem_addr;
   logic [WX_W-1:0]                  wx;
   logic [WX_W-1:0]                  wy;
   logic [W_W-1:0]                   w_in;
   logic                             result_room;

   // Read stage.
   logic                             s1_valid_ff;
   logic                             s1_first_ff;
   logic                             s1_last_ff;
   logic [W_W-1:0]                   w_ff;
   logic [bis_pkg::PIX_W-1:0]        rdata_ff;

   // Multiply stage.
   logic                             s2_valid_ff;
   logic                             s2_first_ff;
   logic                             s2_last_ff;
   logic [2:0][ACC_W-1:0]            prod_in;
   logic [2:0][ACC_W-1:0]            prod_ff;

   // Accumulate stage.
   logic [2:0][ACC_W-1:0]            acc_in;
   logic [2:0][ACC_W-1:0]            acc_ff;
   logic                             result_push;
   logic [bis_pkg::PIX_W-1:0]        result_pixel;
   logic                             out_take;

   // Job selection and the neighbour read of this cycle. The first read of
   // a sample goes straight from the queue head.
   always_comb begin
      head         = job_type'(job_data);
      sel          = (state_ff == BK_GATHER) ? cur_ff : head;
      tap          = (state_ff == BK_GATHER) ? tap_ff : 2'd0;
      start_load   = (state_ff == BK_IDLE) && job_valid && head.is_load;
      start_sample = (state_ff == BK_IDLE) && job_valid && !head.is_load && result_room
                     && (pending_ff < bis_pkg::SLOT_CNT_W'(bis_pkg::RESULT_SLOTS));
      job_ready    = start_load || start_sample;
      read_en      = start_sample || (state_ff == BK_GATHER);
      mem_addr     = sel.addr[tap];

      // Neighbour order: top-left, top-right, bottom-left, bottom-right.
      wx   = tap[0] ? {1'b0, sel.wa} : ONE - {1'b0, sel.wa};
      wy   = tap[1] ? {1'b0, sel.wb} : ONE - {1'b0, sel.wb};
      w_in = W_W'(wx) * W_W'(wy);
   end

   // Sequencer: a load is written straight from idle; a sample takes four reads.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         tap_ff   <= 2'd0;
      end else begin
         unique case (state_ff)
            BK_IDLE: begin
               if (start_sample) begin
                  cur_ff   <= head;
                  tap_ff   <= 2'd1;
                  state_ff <= BK_GATHER;
               end
            end
            BK_GATHER: begin
               tap_ff <= tap_ff + 1'b1;
               if (tap_ff == 2'd3) begin
                  state_ff <= BK_IDLE;
               end
            end
            default: begin
               state_ff <= BK_IDLE;
            end
         endcase
      end
   end

   // Single-port pixel store with registered read data.
   always_ff @(posedge clock) begin
      if (start_load) begin
         mem[mem_addr] <= head.pixel;
      end else if (read_en) begin
         rdata_ff <= mem[mem_addr];
      end
   end

   // Weight travels alongside its read.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= read_en;
      end
   end

   always_ff @(posedge clock) begin
      s1_first_ff <= (tap == 2'd0);
      s1_last_ff  <= (tap == 2'd3);
      w_ff        <= w_in;
   end

   // Weighted channels.
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         prod_in[c] = ACC_W'(rdata_ff[c*bis_pkg::CH_W +: bis_pkg::CH_W]) * ACC_W'(w_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_first_ff <= s1_first_ff;
      s2_last_ff  <= s1_last_ff;
      prod_ff     <= prod_in;
   end

   // Accumulate the four terms. The weights sum to one, so the top byte of
   // the sum never exceeds the channel maximum and dropping the fraction
   // bits is the whole of the truncate and clamp.
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         acc_in[c] = s2_first_ff ? prod_ff[c] : acc_ff[c] + prod_ff[c];
      end
      result_push  = s2_valid_ff && s2_last_ff;
      result_pixel = {acc_in[2][ACC_W-1 -: bis_pkg::CH_W],
                      acc_in[1][ACC_W-1 -: bis_pkg::CH_W],
                      acc_in[0][ACC_W-1 -: bis_pkg::CH_W]};
   end

   always_ff @(posedge clock) begin
      if (s2_valid_ff) begin
         acc_ff <= acc_in;
      end
   end

   // Result slots are reserved when a sample starts, so the result queue
   // always has room when a blend completes.
   assign out_take   = out_valid && out_ready;
   assign pending_in = pending_ff
                       + bis_pkg::SLOT_CNT_W'(start_sample)
                       - bis_pkg::SLOT_CNT_W'(out_take);

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   bis_queue #(
      .DATA_W (bis_pkg::PIX_W)
   ) u_result_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (result_push),
      .push_ready (result_room),
      .push_data  (result_pixel),
      .pop_valid  (out_valid),
      .pop_ready  (out_ready),
      .pop_data   (out_pixel)
   );

endmodule

// ===== sv/bilinear_image_scaler.sv =====
// ----------------------------------------------------------------------------
// bilinear_image_scaler: BGR bilinear scaler. A load is a single store write;
// a sample makes four neighbour reads on the single-port store. Reset and size
// writes rerun the step divider, with req_tready and csr_ready low meanwhile.
// ----------------------------------------------------------------------------
module bilinear_image_scaler #(
   parameter int MAX_WIDTH   = 64,
   parameter int MAX_HEIGHT  = 64,
   parameter int WEIGHT_BITS = 8
) (
   input  logic                                clock,
   input  logic                                reset,

   // Items: tdata = column, row, blue_in, green_in, red_in, zero padding.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [bis_pkg::REQ_DATA_W-1:0]      req_tdata,
   // tuser = operation.
   input  logic                                req_tuser,

   // Results: tdata = blue_out, green_out, red_out.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [bis_pkg::RSP_DATA_W-1:0]      rsp_tdata,

   // Size register writes.
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bis_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [bis_pkg::SIZE_W-1:0]          csr_data
);

   localparam int ADDR_W = $clog2(MAX_WIDTH * MAX_HEIGHT);
   localparam int JOB_W  = 1 + bis_pkg::PIX_W + 2 * WEIGHT_BITS + 4 * ADDR_W;

   logic [bis_pkg::SIZE_W-1:0] src_w_ff;
   logic [bis_pkg::SIZE_W-1:0] src_h_ff;
   logic [bis_pkg::SIZE_W-1:0] tgt_w_ff;
   logic [bis_pkg::SIZE_W-1:0] tgt_h_ff;
   logic                       recompute_ff;

   bis_pkg::sizes_type         sizes;
   bis_pkg::steps_type         steps;
   logic                       div_busy;
   logic                       busy;

   logic                       front_valid;
   logic                       front_ready;
   logic                       job_in_valid;
   logic                       job_in_ready;
   logic [JOB_W-1:0]           job_in_data;
   logic                       job_out_valid;
   logic                       job_out_ready;
   logic [JOB_W-1:0]           job_out_data;

   // Size registers; every write to one of them reruns the step divider.
   always_ff @(posedge clock) begin
      if (reset) begin
         src_w_ff     <= bis_pkg::RESET_SOURCE_WIDTH;
         src_h_ff     <= bis_pkg::RESET_SOURCE_HEIGHT;
         tgt_w_ff     <= bis_pkg::RESET_TARGET_WIDTH;
         tgt_h_ff     <= bis_pkg::RESET_TARGET_HEIGHT;
         recompute_ff <= 1'b1;
      end else begin
         recompute_ff <= 1'b0;
         if (csr_valid && csr_ready) begin
            unique case (bis_pkg::csr_index_type'(csr_index))
               bis_pkg::REG_SOURCE_WIDTH: begin
                  src_w_ff     <= csr_data;
                  recompute_ff <= 1'b1;
               end
               bis_pkg::REG_SOURCE_HEIGHT: begin
                  src_h_ff     <= csr_data;
                  recompute_ff <= 1'b1;
               end
               bis_pkg::REG_TARGET_WIDTH: begin
                  tgt_w_ff     <= csr_data;
                  recompute_ff <= 1'b1;
               end
               bis_pkg::REG_TARGET_HEIGHT: begin
                  tgt_h_ff     <= csr_data;
                  recompute_ff <= 1'b1;
               end
               default: begin
               end
            endcase
         end
      end
   end

   // Effective sizes: sources saturate to between two and the store, targets to at least two.
   always_comb begin
      if (src_w_ff < bis_pkg::MIN_SIZE) begin
         sizes.src_w = bis_pkg::MIN_SIZE;
      end else if (int'(src_w_ff) > MAX_WIDTH) begin
         sizes.src_w = bis_pkg::SIZE_W'(MAX_WIDTH);
      end else begin
         sizes.src_w = src_w_ff;
      end
      if (src_h_ff < bis_pkg::MIN_SIZE) begin
         sizes.src_h = bis_pkg::MIN_SIZE;
      end else if (int'(src_h_ff) > MAX_HEIGHT) begin
         sizes.src_h = bis_pkg::SIZE_W'(MAX_HEIGHT);
      end else begin
         sizes.src_h = src_h_ff;
      end
      sizes.tgt_w = (tgt_w_ff < bis_pkg::MIN_SIZE) ? bis_pkg::MIN_SIZE : tgt_w_ff;
      sizes.tgt_h = (tgt_h_ff < bis_pkg::MIN_SIZE) ? bis_pkg::MIN_SIZE : tgt_h_ff;
   end

   // Nothing is taken while the steps are being worked out.
   assign busy        = recompute_ff || div_busy;
   assign csr_ready   = !busy;
   assign front_valid = req_tvalid && !busy;
   assign req_tready  = front_ready && !busy;

   bis_step_div u_step_div (
      .clock (clock),
      .reset (reset),
      .start (recompute_ff),
      .sizes (sizes),
      .steps (steps),
      .busy  (div_busy)
   );

   bis_front #(
      .MAX_WIDTH   (MAX_WIDTH),
      .MAX_HEIGHT  (MAX_HEIGHT),
      .WEIGHT_BITS (WEIGHT_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_op     (req_tuser),
      .in_column (req_tdata[0 +: bis_pkg::COL_W]),
      .in_row    (req_tdata[bis_pkg::COL_W +: bis_pkg::ROW_W]),
      .in_pixel  (req_tdata[bis_pkg::COL_W + bis_pkg::ROW_W +: bis_pkg::PIX_W]),
      .sizes     (sizes),
      .steps     (steps),
      .job_valid (job_in_valid),
      .job_ready (job_in_ready),
      .job_data  (job_in_data)
   );

   bis_queue #(
      .DATA_W (JOB_W)
   ) u_job_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (job_in_valid),
      .push_ready (job_in_ready),
      .push_data  (job_in_data),
      .pop_valid  (job_out_valid),
      .pop_ready  (job_out_ready),
      .pop_data   (job_out_data)
   );

   bis_back #(
      .MAX_WIDTH   (MAX_WIDTH),
      .MAX_HEIGHT  (MAX_HEIGHT),
      .WEIGHT_BITS (WEIGHT_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_out_valid),
      .job_ready (job_out_ready),
      .job_data  (job_out_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_pixel (rsp_tdata)
   );

endmodule
